@@ rtl/ppv_pkg.sv @@
// Shared types, constants and register indexes for the point-to-viewport projection block.
package ppv_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int NDC_BITS          = 44;
   localparam int DIV_STAGES        = 22;
   localparam int BITS_PER_STAGE    = NDC_BITS / DIV_STAGES;
   localparam int REG_COUNT         = 7;
   localparam int ADDR_W            = 6;

   localparam logic [2:0] REG_COL_X_LOW  = 3'd0;
   localparam logic [2:0] REG_COL_X_HIGH = 3'd1;
   localparam logic [2:0] REG_COL_Y_LOW  = 3'd2;
   localparam logic [2:0] REG_COL_Y_HIGH = 3'd3;
   localparam logic [2:0] REG_COL_W_LOW  = 3'd4;
   localparam logic [2:0] REG_COL_W_HIGH = 3'd5;
   localparam logic [2:0] REG_VIEWPORT   = 3'd6;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic               w_zero;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [63:0]         rem_x;
      logic [63:0]         rem_y;
      logic [NDC_BITS-1:0] num_x;
      logic [NDC_BITS-1:0] num_y;
      logic [NDC_BITS-1:0] quo_x;
      logic [NDC_BITS-1:0] quo_y;
      logic [63:0]         den;
      logic                neg_x;
      logic                neg_y;
      logic                ovf_x;
      logic                ovf_y;
      logic                w_zero;
   } div_type;

endpackage

@@ rtl/project_point_to_viewport.sv @@
// Top level of the perspective projection and viewport mapping pipeline.

// Projects one world point per cycle to viewport pixels. An accepted point
// passes through one stage of nine 32x32 matrix products, one stage
// for the clip sums, one stage to set up the divisions, 22 stages of the
// restoring dividers for x/w and y/w (two quotient bits per stage), then one
// stage each for the NDC factors, the extent products and the final offset
// and clamp. The pipeline advances as a whole; when a result waits at the
// output and is not taken, every stage holds. Registers are written through
// the APB port at byte address 8*i and must only be changed while the
// pipeline is empty.
module project_point_to_viewport #(
   parameter int FRAC_BITS = ppv_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ppv_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ppv_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ppv_pkg::ADDR_W-1:0] paddr,
   input  logic [63:0]                pwdata,
   output logic [63:0]                prdata,
   output logic                       pready
);

   localparam int NDC   = ppv_pkg::NDC_BITS;
   localparam int DS    = ppv_pkg::DIV_STAGES;
   localparam int FAC_W = NDC + 3;
   localparam int DEPTH = DS + 6;

   // Configuration registers.
   logic [63:0] cfg_ff [ppv_pkg::REG_COUNT];
   logic [2:0]  cfg_idx;

   assign cfg_idx = paddr[5:3];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ppv_pkg::REG_COUNT; i++) cfg_ff[i] <= '0;
      end else if (psel && penable && pwrite && cfg_idx < 3'(ppv_pkg::REG_COUNT)) begin
         cfg_ff[cfg_idx] <= pwdata;
      end
   end

   always_comb begin
      if (cfg_idx < 3'(ppv_pkg::REG_COUNT)) prdata = cfg_ff[cfg_idx];
      else                                  prdata = '0;
   end

   // Pipeline control: all stages move together.
   logic [DEPTH-1:0] vld_ff;
   logic             en;

   assign en        = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
   end

   // Stage 1: matrix products.
   logic signed [63:0] prod_ff [9];
   logic signed [63:0] prod_in [9];
   logic signed [31:0] mat [9];

   always_comb begin
      mat[0] = cfg_ff[ppv_pkg::REG_COL_X_LOW][31:0];
      mat[1] = cfg_ff[ppv_pkg::REG_COL_X_LOW][63:32];
      mat[2] = cfg_ff[ppv_pkg::REG_COL_X_HIGH][31:0];
      mat[3] = cfg_ff[ppv_pkg::REG_COL_Y_LOW][31:0];
      mat[4] = cfg_ff[ppv_pkg::REG_COL_Y_LOW][63:32];
      mat[5] = cfg_ff[ppv_pkg::REG_COL_Y_HIGH][31:0];
      mat[6] = cfg_ff[ppv_pkg::REG_COL_W_LOW][31:0];
      mat[7] = cfg_ff[ppv_pkg::REG_COL_W_LOW][63:32];
      mat[8] = cfg_ff[ppv_pkg::REG_COL_W_HIGH][31:0];
      for (int c = 0; c < 3; c++) begin
         prod_in[3*c]   = req_data.world_x * mat[3*c];
         prod_in[3*c+1] = req_data.world_y * mat[3*c+1];
         prod_in[3*c+2] = req_data.world_z * mat[3*c+2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) prod_ff <= prod_in;
   end

   // Stage 2: clip sums.
   logic signed [63:0] clip_ff [3];
   logic signed [63:0] clip_in [3];
   logic signed [31:0] ofs [3];

   always_comb begin
      ofs[0] = cfg_ff[ppv_pkg::REG_COL_X_HIGH][63:32];
      ofs[1] = cfg_ff[ppv_pkg::REG_COL_Y_HIGH][63:32];
      ofs[2] = cfg_ff[ppv_pkg::REG_COL_W_HIGH][63:32];
      for (int c = 0; c < 3; c++) begin
         clip_in[c] = (prod_ff[3*c] >>> FRAC_BITS) + (prod_ff[3*c+1] >>> FRAC_BITS)
                    + (prod_ff[3*c+2] >>> FRAC_BITS) + 64'(ofs[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) clip_ff <= clip_in;
   end

   // Stage 3: division setup. The dividend is |clip| scaled by 2^FRAC_BITS;
   // its bits above the quotient width seed the remainder.
   ppv_pkg::div_type div_ff [DS+1];
   ppv_pkg::div_type div_in [DS+1];

   always_comb begin
      logic [63:0] un_x;
      logic [63:0] un_y;
      logic [63:0] sh_x;
      logic [63:0] sh_y;
      un_x = clip_ff[0][63] ? 64'(-clip_ff[0]) : 64'(clip_ff[0]);
      un_y = clip_ff[1][63] ? 64'(-clip_ff[1]) : 64'(clip_ff[1]);
      sh_x = un_x << FRAC_BITS;
      sh_y = un_y << FRAC_BITS;
      div_in[0].den    = clip_ff[2][63] ? 64'(-clip_ff[2]) : 64'(clip_ff[2]);
      div_in[0].neg_x  = clip_ff[0][63] ^ clip_ff[2][63];
      div_in[0].neg_y  = clip_ff[1][63] ^ clip_ff[2][63];
      div_in[0].w_zero = clip_ff[2] == '0;
      div_in[0].rem_x  = un_x >> (NDC - FRAC_BITS);
      div_in[0].rem_y  = un_y >> (NDC - FRAC_BITS);
      div_in[0].ovf_x  = (un_x >> (NDC - FRAC_BITS)) >= div_in[0].den;
      div_in[0].ovf_y  = (un_y >> (NDC - FRAC_BITS)) >= div_in[0].den;
      div_in[0].num_x  = sh_x[NDC-1:0];
      div_in[0].num_y  = sh_y[NDC-1:0];
      div_in[0].quo_x  = '0;
      div_in[0].quo_y  = '0;
   end

   // Divider stages, each retiring two quotient bits per coordinate.
   for (genvar g = 0; g < DS; g++) begin : g_div
      always_comb begin
         ppv_pkg::div_type s;
         logic [64:0]      r;
         s = div_ff[g];
         for (int k = 0; k < ppv_pkg::BITS_PER_STAGE; k++) begin
            r       = {s.rem_x, s.num_x[NDC-1]};
            s.num_x = {s.num_x[NDC-2:0], 1'b0};
            if (r >= {1'b0, s.den}) begin
               r       = r - {1'b0, s.den};
               s.quo_x = {s.quo_x[NDC-2:0], 1'b1};
            end else begin
               s.quo_x = {s.quo_x[NDC-2:0], 1'b0};
            end
            s.rem_x = r[63:0];
            r       = {s.rem_y, s.num_y[NDC-1]};
            s.num_y = {s.num_y[NDC-2:0], 1'b0};
            if (r >= {1'b0, s.den}) begin
               r       = r - {1'b0, s.den};
               s.quo_y = {s.quo_y[NDC-2:0], 1'b1};
            end else begin
               s.quo_y = {s.quo_y[NDC-2:0], 1'b0};
            end
            s.rem_y = r[63:0];
         end
         div_in[g+1] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (en) div_ff <= div_in;
   end

   // NDC factors: clamp large quotients, apply sign, form 1 + x and 1 - y.
   logic signed [FAC_W-1:0] fac_x_ff, fac_y_ff, fac_x_in, fac_y_in;
   logic                    fz_ff;

   always_comb begin
      logic signed [FAC_W-1:0] m_x;
      logic signed [FAC_W-1:0] m_y;
      logic signed [FAC_W-1:0] one;
      one = FAC_W'(1) <<< FRAC_BITS;
      m_x = div_ff[DS].ovf_x ? (FAC_W'(1) <<< NDC) : FAC_W'({1'b0, div_ff[DS].quo_x});
      m_y = div_ff[DS].ovf_y ? (FAC_W'(1) <<< NDC) : FAC_W'({1'b0, div_ff[DS].quo_y});
      if (div_ff[DS].neg_x) m_x = -m_x;
      if (div_ff[DS].neg_y) m_y = -m_y;
      fac_x_in = one + m_x;
      fac_y_in = one - m_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fac_x_ff <= fac_x_in;
         fac_y_ff <= fac_y_in;
         fz_ff    <= div_ff[DS].w_zero;
      end
   end

   // Extent products.
   logic signed [63:0] ext_x_ff, ext_y_ff;
   logic               ez_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ext_x_ff <= 64'(fac_x_ff) * $signed({1'b0, cfg_ff[ppv_pkg::REG_VIEWPORT][47:32]});
         ext_y_ff <= 64'(fac_y_ff) * $signed({1'b0, cfg_ff[ppv_pkg::REG_VIEWPORT][63:48]});
         ez_ff    <= fz_ff;
      end
   end

   // Halve, offset by the rectangle minimum and clamp to 32 bits; a zero w gives zero coordinates.
   ppv_pkg::rsp_type out_ff, out_in;

   always_comb begin
      logic signed [63:0] t_x;
      logic signed [63:0] t_y;
      logic signed [15:0] min_x;
      logic signed [15:0] min_y;
      logic               sat_x;
      logic               sat_y;
      min_x = cfg_ff[ppv_pkg::REG_VIEWPORT][15:0];
      min_y = cfg_ff[ppv_pkg::REG_VIEWPORT][31:16];
      t_x   = (ext_x_ff >>> 1) + (64'(min_x) <<< FRAC_BITS);
      t_y   = (ext_y_ff >>> 1) + (64'(min_y) <<< FRAC_BITS);
      sat_x = 1'b1;
      sat_y = 1'b1;
      if (t_x > 64'sd2147483647)       out_in.screen_x = 32'sh7fffffff;
      else if (t_x < -64'sd2147483648) out_in.screen_x = 32'sh80000000;
      else begin
         out_in.screen_x = t_x[31:0];
         sat_x           = 1'b0;
      end
      if (t_y > 64'sd2147483647)       out_in.screen_y = 32'sh7fffffff;
      else if (t_y < -64'sd2147483648) out_in.screen_y = 32'sh80000000;
      else begin
         out_in.screen_y = t_y[31:0];
         sat_y           = 1'b0;
      end
      out_in.w_zero    = ez_ff;
      out_in.saturated = sat_x || sat_y;
      if (ez_ff) begin
         out_in.screen_x  = '0;
         out_in.screen_y  = '0;
         out_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) out_ff <= out_in;
   end

   assign rsp_data = out_ff;

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the output stall");

   a_wzero_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.w_zero |->
         rsp_data.screen_x == 0 && rsp_data.screen_y == 0 && !rsp_data.saturated)
      else $error("zero w result carries coordinates or saturation");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.screen_x == 32'sh7fffffff || rsp_data.screen_x == 32'sh80000000 ||
         rsp_data.screen_y == 32'sh7fffffff || rsp_data.screen_y == 32'sh80000000)
      else $error("saturation flag set with no coordinate at a limit");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
